// ----- src/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg: shared types for the RGB to HSV color classifier
// Level, pipeline word and result types, color codes and register indexes.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned HUE_W       = 13;
  localparam int unsigned CLASS_W     = 4;
  localparam int unsigned DIV_STEPS   = 10;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 1'b1;

  // Hue sector bases in 1/16 degree
  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 13'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 13'd1920;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 13'd3840;
  localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 13'd5760;

  typedef enum logic [CLASS_W-1:0] {
    CLS_RED     = 4'd0,
    CLS_GREEN   = 4'd1,
    CLS_BLUE    = 4'd2,
    CLS_CYAN    = 4'd3,
    CLS_MAGENTA = 4'd4,
    CLS_ORANGE  = 4'd5,
    CLS_VIOLET  = 4'd6,
    CLS_WHITE   = 4'd7,
    CLS_YELLOW  = 4'd8,
    CLS_BLACK   = 4'd9
  } color_e;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } levels_t;

  // Word leaving the front end: levels plus hue setup
  typedef struct packed {
    levels_t                lv;
    level_t                 mx;
    level_t                 delta;
    level_t                 hdiff;  // magnitude of the hue numerator difference
    logic                   hneg;   // difference is negative
    logic [HUE_W-1:0]       hbase;
  } hsv_pre_t;

  // One restoring-division lane: partial remainder, unconsumed numerator bits, quotient bits
  typedef struct packed {
    level_t                 rem;
    logic [DIV_STEPS-1:0]   lo;
    logic [DIV_STEPS-1:0]   q;
  } div_lane_t;

  typedef struct packed {
    hsv_pre_t               pre;
    div_lane_t              hue;
    div_lane_t              sat;
  } div_word_t;

  typedef struct packed {
    color_e                 cls;
    level_t                 bright;
    level_t                 sat;
    logic [HUE_W-1:0]       hue;
    levels_t                lv;
  } result_t;

endpackage

// ----- src/rhc_front.sv -----
// ----------------------------------------------------------------------------
// rhc_front: pulse to level conversion and hue setup
// Two register stages: clamp and invert, then max, min, delta and sector.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter int unsigned PULSE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [PULSE_BITS-1:0] red_pulse_i,
  input  logic [PULSE_BITS-1:0] green_pulse_i,
  input  logic [PULSE_BITS-1:0] blue_pulse_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output rhc_pkg::hsv_pre_t     m_data_o
);

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  rhc_pkg::levels_t  lv_d, lv_q;
  rhc_pkg::hsv_pre_t pre_d, pre_q;
  logic              over_r, over_g, over_b;
  rhc_pkg::level_t   mx, mn;
  rhc_pkg::level_t   diff_a, diff_b;

  assign rdy2      = !v2_q || m_ready_i;
  assign rdy1      = !v1_q || rdy2;
  assign s_ready_o = rdy1;

  // Saturate pulses above 255: the level drops to zero
  if (PULSE_BITS > 8) begin : g_over
    assign over_r = |red_pulse_i[PULSE_BITS-1:8];
    assign over_g = |green_pulse_i[PULSE_BITS-1:8];
    assign over_b = |blue_pulse_i[PULSE_BITS-1:8];
  end else begin : g_no_over
    assign over_r = 1'b0;
    assign over_g = 1'b0;
    assign over_b = 1'b0;
  end

  always_comb begin
    lv_d.red   = over_r ? '0 : ~red_pulse_i[7:0];
    lv_d.green = over_g ? '0 : ~green_pulse_i[7:0];
    lv_d.blue  = over_b ? '0 : ~blue_pulse_i[7:0];
  end

  always_comb begin
    mx = (lv_q.red > lv_q.green) ? lv_q.red : lv_q.green;
    mn = (lv_q.red < lv_q.green) ? lv_q.red : lv_q.green;
    if (lv_q.blue > mx) begin
      mx = lv_q.blue;
    end
    if (lv_q.blue < mn) begin
      mn = lv_q.blue;
    end
    if (lv_q.red >= mx) begin
      diff_a = lv_q.green;
      diff_b = lv_q.blue;
    end else if (lv_q.green >= mx) begin
      diff_a = lv_q.blue;
      diff_b = lv_q.red;
    end else begin
      diff_a = lv_q.red;
      diff_b = lv_q.green;
    end
    pre_d.lv    = lv_q;
    pre_d.mx    = mx;
    pre_d.delta = mx - mn;
    pre_d.hneg  = diff_a < diff_b;
    pre_d.hdiff = pre_d.hneg ? (diff_b - diff_a) : (diff_a - diff_b);
    if (lv_q.red >= mx) begin
      pre_d.hbase = pre_d.hneg ? rhc_pkg::HUE_BASE_WRAP : rhc_pkg::HUE_BASE_RED;
    end else if (lv_q.green >= mx) begin
      pre_d.hbase = rhc_pkg::HUE_BASE_GREEN;
    end else begin
      pre_d.hbase = rhc_pkg::HUE_BASE_BLUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_valid_i) begin
      lv_q <= lv_d;
    end
    if (rdy2 && v1_q) begin
      pre_q <= pre_d;
    end
  end

  assign m_valid_o = v2_q;
  assign m_data_o  = pre_q;

endmodule

// ----- src/rhc_divider.sv -----
// ----------------------------------------------------------------------------
// rhc_divider: pipelined restoring divider, two lanes
// One quotient bit per stage for 960*diff/delta and 255*delta/max.
// ----------------------------------------------------------------------------
module rhc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  rhc_pkg::hsv_pre_t  s_data_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output rhc_pkg::div_word_t m_data_o
);

  localparam int unsigned N     = rhc_pkg::DIV_STEPS;
  localparam int unsigned NUM_W = rhc_pkg::LEVEL_W + N;

  function automatic rhc_pkg::div_lane_t lane_init(logic [NUM_W-1:0] num);
    rhc_pkg::div_lane_t l;
    l.rem = num[NUM_W-1:N];
    l.lo  = num[N-1:0];
    l.q   = '0;
    return l;
  endfunction

  function automatic rhc_pkg::div_lane_t lane_step(rhc_pkg::div_lane_t l,
                                                   rhc_pkg::level_t d);
    rhc_pkg::div_lane_t       n;
    logic [rhc_pkg::LEVEL_W:0] t;
    logic                      hit;
    t     = {l.rem, l.lo[N-1]};
    hit   = t >= {1'b0, d};
    n.rem = hit ? rhc_pkg::level_t'(t - {1'b0, d}) : t[rhc_pkg::LEVEL_W-1:0];
    n.lo  = {l.lo[N-2:0], 1'b0};
    n.q   = {l.q[N-2:0], hit};
    return n;
  endfunction

  function automatic rhc_pkg::div_word_t word_init(rhc_pkg::hsv_pre_t p);
    rhc_pkg::div_word_t w;
    logic [NUM_W-1:0]   hnum, snum;
    // 960*x = 1024*x - 64*x, 255*d = 256*d - d
    hnum  = ({p.hdiff, 10'd0}) - NUM_W'({p.hdiff, 6'd0});
    snum  = NUM_W'({p.delta, 8'd0}) - NUM_W'(p.delta);
    w.pre = p;
    w.hue = lane_init(hnum);
    w.sat = lane_init(snum);
    return w;
  endfunction

  logic [N-1:0]       v_q, rdy, in_v;
  rhc_pkg::div_word_t st_q [N];
  rhc_pkg::div_word_t in_st [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    rhc_pkg::div_word_t nxt;

    if (k == 0) begin : g_first
      assign in_v[k]  = s_valid_i;
      assign in_st[k] = word_init(s_data_i);
    end else begin : g_next
      assign in_v[k]  = v_q[k-1];
      assign in_st[k] = st_q[k-1];
    end

    if (k == N - 1) begin : g_last_rdy
      assign rdy[k] = !v_q[k] || m_ready_i;
    end else begin : g_mid_rdy
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    always_comb begin
      nxt     = in_st[k];
      nxt.hue = lane_step(in_st[k].hue, in_st[k].pre.delta);
      nxt.sat = lane_step(in_st[k].sat, in_st[k].pre.mx);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= in_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && in_v[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign s_ready_o = rdy[0];
  assign m_valid_o = v_q[N-1];
  assign m_data_o  = st_q[N-1];

endmodule

// ----- src/rhc_back.sv -----
// ----------------------------------------------------------------------------
// rhc_back: hue assembly and color classification
// Applies the sector base and rounding, then bins by value and hue.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rhc_pkg::level_t    white_level_i,
  input  rhc_pkg::level_t    black_level_i,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  rhc_pkg::div_word_t s_data_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output rhc_pkg::result_t   m_data_o
);

  localparam int unsigned HW = rhc_pkg::HUE_W;

  // Hue bin bounds in 1/16 degree
  localparam logic [HW-1:0] BIN_ORANGE  = 13'd240;
  localparam logic [HW-1:0] BIN_YELLOW  = 13'd400;
  localparam logic [HW-1:0] BIN_GREEN   = 13'd1200;
  localparam logic [HW-1:0] BIN_CYAN    = 13'd2640;
  localparam logic [HW-1:0] BIN_BLUE    = 13'd3520;
  localparam logic [HW-1:0] BIN_VIOLET  = 13'd3760;
  localparam logic [HW-1:0] BIN_MAGENTA = 13'd4320;
  localparam logic [HW-1:0] BIN_RED     = 13'd5280;

  logic             v_q, rdy;
  rhc_pkg::result_t res_d, res_q;
  logic             grey, round_up;
  logic [HW-1:0]    q_ext, hue;

  assign rdy = !v_q || m_ready_i;

  always_comb begin
    grey     = s_data_i.pre.delta == '0;
    q_ext    = HW'(s_data_i.hue.q);
    round_up = s_data_i.hue.rem != '0;
    // Negative difference: subtract the ceiling of the quotient
    if (s_data_i.pre.hneg) begin
      hue = s_data_i.pre.hbase - q_ext - HW'(round_up);
    end else begin
      hue = s_data_i.pre.hbase + q_ext;
    end
    if (grey) begin
      hue = '0;
    end

    res_d.lv     = s_data_i.pre.lv;
    res_d.hue    = hue;
    res_d.sat    = grey ? '0 : s_data_i.sat.q[rhc_pkg::LEVEL_W-1:0];
    res_d.bright = s_data_i.pre.mx;

    if (s_data_i.pre.mx > white_level_i) begin
      res_d.cls = rhc_pkg::CLS_WHITE;
    end else if (s_data_i.pre.mx < black_level_i) begin
      res_d.cls = rhc_pkg::CLS_BLACK;
    end else if (hue >= BIN_RED || hue < BIN_ORANGE) begin
      res_d.cls = rhc_pkg::CLS_RED;
    end else if (hue < BIN_YELLOW) begin
      res_d.cls = rhc_pkg::CLS_ORANGE;
    end else if (hue < BIN_GREEN) begin
      res_d.cls = rhc_pkg::CLS_YELLOW;
    end else if (hue < BIN_CYAN) begin
      res_d.cls = rhc_pkg::CLS_GREEN;
    end else if (hue < BIN_BLUE) begin
      res_d.cls = rhc_pkg::CLS_CYAN;
    end else if (hue < BIN_VIOLET) begin
      res_d.cls = rhc_pkg::CLS_BLUE;
    end else if (hue < BIN_MAGENTA) begin
      res_d.cls = rhc_pkg::CLS_VIOLET;
    end else begin
      res_d.cls = rhc_pkg::CLS_MAGENTA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && s_valid_i) begin
      res_q <= res_d;
    end
  end

  assign s_ready_o = rdy;
  assign m_valid_o = v_q;
  assign m_data_o  = res_q;

endmodule

// ----- src/rgb_hsv_color_classifier.sv -----
// ----------------------------------------------------------------------------
// rgb_hsv_color_classifier: RGB to HSV conversion with color classification
//
// Input stream: each word carries three filter pulse widths. Each is clamped
// to 255 and inverted to a level; the levels go to HSV (hue in 1/16 degree,
// saturation scaled to 255, brightness = max level) and to one of ten color
// codes by brightness against white/black thresholds and by hue bins.
// Output stream: one result word per input word, in order.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 white level, 1 black level); write only while the pipeline is empty.
// Stages: two front, ten divider (one quotient bit each for the hue and
// saturation divisions), one output. Throughput is one word per cycle
// while the receiver accepts. Every stage holds its word while the stage
// after it is full and stalled, so a stalled receiver backs up the
// pipeline and s_axis_tready falls only once all stages are occupied.
// Reset empties the pipeline and sets thresholds to 250 and 5.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier #(
  parameter int unsigned PULSE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // red_pulse, green_pulse, blue_pulse, zero pad
  input  logic [((3*PULSE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red_level, green_level, blue_level, hue_sixteenths, saturation,
  // brightness, color_class, zero pad
  output logic [rhc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rhc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned PAD_W = rhc_pkg::OUT_TDATA_W - rhc_pkg::CLASS_W
                                  - 5 * rhc_pkg::LEVEL_W - rhc_pkg::HUE_W;

  rhc_pkg::level_t    white_q, black_q;
  logic               pre_v, pre_rdy, div_v, div_rdy;
  rhc_pkg::hsv_pre_t  pre;
  rhc_pkg::div_word_t dw;
  rhc_pkg::result_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= 8'd250;
      black_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rhc_pkg::REG_WHITE_LEVEL: white_q <= cfg_wdata_i;
        rhc_pkg::REG_BLACK_LEVEL: black_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rhc_front #(
    .PULSE_BITS(PULSE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .red_pulse_i  (s_axis_tdata[PULSE_BITS-1:0]),
    .green_pulse_i(s_axis_tdata[2*PULSE_BITS-1:PULSE_BITS]),
    .blue_pulse_i (s_axis_tdata[3*PULSE_BITS-1:2*PULSE_BITS]),
    .m_valid_o    (pre_v),
    .m_ready_i    (pre_rdy),
    .m_data_o     (pre)
  );

  rhc_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(pre_v),
    .s_ready_o(pre_rdy),
    .s_data_i (pre),
    .m_valid_o(div_v),
    .m_ready_i(div_rdy),
    .m_data_o (dw)
  );

  rhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .white_level_i(white_q),
    .black_level_i(black_q),
    .s_valid_i    (div_v),
    .s_ready_o    (div_rdy),
    .s_data_i     (dw),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (res)
  );

  assign m_axis_tdata = {PAD_W'(0), res.cls, res.bright, res.sat, res.hue,
                         res.lv.blue, res.lv.green, res.lv.red};

  // Brightness is the largest level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.bright >= res.lv.red && res.bright >= res.lv.green &&
                       res.bright >= res.lv.blue))
    else $error("brightness below a level");

  // Hue stays inside one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.hue < rhc_pkg::HUE_BASE_WRAP)
    else $error("hue out of range");

  // Zero saturation only for grey, where hue is zero too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.sat == '0) |-> res.hue == '0)
    else $error("hue set on grey color");

  // White only above the white threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.cls == rhc_pkg::CLS_WHITE) |-> res.bright > white_q)
    else $error("white class below threshold");

endmodule
